FILE: hw/rtl/fct_pkg.sv
// Shared types and constants for the frustum cull test block.
package fct_pkg;

    localparam int NUM_REGS   = 6;
    localparam int REG_WIDTH  = 64;
    localparam int IDX_WIDTH  = 3;
    localparam int PF_WIDTH   = 16;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2,
        OP_BOX_ALT = 2'd3
    } t_op;

    // Unpacked plane fields, all signed 16 bits.
    typedef struct packed {
        logic signed [PF_WIDTH-1:0] off;
        logic signed [PF_WIDTH-1:0] nz;
        logic signed [PF_WIDTH-1:0] ny;
        logic signed [PF_WIDTH-1:0] nx;
    } t_plane;

endpackage

FILE: hw/rtl/fct_plane_eval.sv
// One plane: six products, sums and the reject decision, in three register stages.
module fct_plane_eval #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  fct_pkg::t_plane      i_plane,
    input  logic                 i_is_box,
    input  logic                 i_is_sphere,
    input  logic signed [CW-1:0] i_lo_x,
    input  logic signed [CW-1:0] i_lo_y,
    input  logic signed [CW-1:0] i_lo_z,
    input  logic signed [CW-1:0] i_hi_x,
    input  logic signed [CW-1:0] i_hi_y,
    input  logic signed [CW-1:0] i_hi_z,
    input  logic        [CW-2:0] i_radius,
    output logic                 o_reject
);
    import fct_pkg::*;

    localparam int PW = CW + PF_WIDTH;   // product width
    localparam int SW = PW + 3;          // sum width with offset and radius

    // Stage 1: six products (lo and hi of each axis), offset and bound.
    logic signed [PW-1:0] r_px_lo, r_px_hi, r_py_lo, r_py_hi, r_pz_lo, r_pz_hi;
    logic signed [SW-1:0] r_bias;
    logic                 r_box1;

    // A distance compared to minus the radius equals distance plus radius against zero.
    always_ff @(posedge i_clk) begin
        r_px_lo <= PW'(i_plane.nx * i_lo_x);
        r_px_hi <= PW'(i_plane.nx * i_hi_x);
        r_py_lo <= PW'(i_plane.ny * i_lo_y);
        r_py_hi <= PW'(i_plane.ny * i_hi_y);
        r_pz_lo <= PW'(i_plane.nz * i_lo_z);
        r_pz_hi <= PW'(i_plane.nz * i_hi_z);
        r_bias  <= (i_is_sphere ? SW'($signed({1'b0, i_radius})) <<< 14 : SW'(0))
                   - (SW'(i_plane.off) <<< 14);
        r_box1  <= i_is_box;
    end

    // Stage 2: xy pair sums per corner pair and z term with bias.
    logic signed [SW-1:0] r_xy [4];
    logic signed [SW-1:0] r_zb [2];
    logic                 r_box2;

    always_ff @(posedge i_clk) begin
        r_xy[0] <= SW'(r_px_lo) + SW'(r_py_lo);
        r_xy[1] <= SW'(r_px_lo) + SW'(r_py_hi);
        r_xy[2] <= SW'(r_px_hi) + SW'(r_py_lo);
        r_xy[3] <= SW'(r_px_hi) + SW'(r_py_hi);
        r_zb[0] <= SW'(r_pz_lo) + r_bias;
        r_zb[1] <= SW'(r_pz_hi) + r_bias;
        r_box2  <= r_box1;
    end

    // Stage 3: eight corner distances; non-box shapes use only the lo corner.
    logic [7:0] w_neg;
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            logic signed [SW-1:0] d;
            d = r_xy[c >> 1] + r_zb[c & 1];
            w_neg[c] = d[SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_reject <= r_box2 ? (&w_neg) : w_neg[0];
    end

endmodule

FILE: hw/rtl/frustum_cull_test.sv
// Top level of the six-plane frustum cull test.
// An accepted start beat leaves through the plane stages and the merge register; o_valid rides a valid shift register.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Each plane runs a three-stage multiply-add pipeline, then a stage merges six rejects.
// Reset (synchronous, active low) clears the planes to zero and drains all valid bits.
module frustum_cull_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_z,
    input  logic        [COORD_WIDTH-2:0] i_radius,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fct_pkg::IDX_WIDTH-1:0] i_cfg_index,
    input  logic [fct_pkg::REG_WIDTH-1:0] i_cfg_data,
    output logic                          o_valid,
    output logic                          o_visible
);
    import fct_pkg::*;

    t_plane     r_planes [NUM_REGS];
    logic [3:0] r_vld;
    logic [NUM_REGS-1:0] w_rej;
    logic       w_acc;
    t_op        w_op;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = start && !busy;
    assign w_op        = t_op'(i_operation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_planes[i] <= '0;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index < IDX_WIDTH'(NUM_REGS)) begin
            r_planes[i_cfg_index] <= t_plane'(i_cfg_data);
        end
    end

    genvar g;
    for (g = 0; g < NUM_REGS; g++) begin : g_plane
        fct_plane_eval #(.CW(COORD_WIDTH)) u_eval (
            .i_clk       (i_clk),
            .i_plane     (r_planes[g]),
            .i_is_box    (w_op == OP_BOX || w_op == OP_BOX_ALT),
            .i_is_sphere (w_op == OP_SPHERE),
            .i_lo_x      (i_pos_x),
            .i_lo_y      (i_pos_y),
            .i_lo_z      (i_pos_z),
            .i_hi_x      (i_max_x),
            .i_hi_y      (i_max_y),
            .i_hi_z      (i_max_z),
            .i_radius    (i_radius),
            .o_reject    (w_rej[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        o_visible <= ~|w_rej;
    end
    assign o_valid = r_vld[3];

    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##4 o_valid) else $error("accepted item lost in pipeline");
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, 4)) else $error("result without accepted item");
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("pipeline signalled busy");

endmodule

FILE: tb/tb_frustum_cull_test.sv
// Self-checking testbench for the six-plane frustum cull test block.
module tb_frustum_cull_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fct_pkg::*;

    typedef struct {
        t_op                op;
        logic signed [15:0] px, py, pz, mx, my, mz;
        logic        [14:0] rad;
    } t_query;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] i_operation = '0;
    logic signed [15:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [15:0] i_max_x = '0, i_max_y = '0, i_max_z = '0;
    logic [14:0] i_radius = '0;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [IDX_WIDTH-1:0] i_cfg_index = '0;
    logic [REG_WIDTH-1:0] i_cfg_data = '0;
    logic o_valid, o_visible;

    frustum_cull_test dut (.*);

    always #4 i_clk = ~i_clk;

    t_query     pending_q[$];
    logic       visible_q[$];
    t_plane     planes[NUM_REGS];
    int         errors = 0;
    int         idle_left = 0;
    bit         allow_idle = 1;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // Exact signed distance in Q.14 units.
    function automatic longint plane_distance(t_plane p, longint x, longint y, longint z);
        return longint'(p.nx) * x + longint'(p.ny) * y + longint'(p.nz) * z
             - longint'(p.off) * 16384;
    endfunction

    function automatic logic predict_visible(t_query q);
        longint x, y, z;
        int below;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (q.op == OP_POINT) begin
                if (plane_distance(planes[i], q.px, q.py, q.pz) < 0) return 0;
            end else if (q.op == OP_SPHERE) begin
                if (plane_distance(planes[i], q.px, q.py, q.pz) < -(longint'(q.rad) * 16384))
                    return 0;
            end else begin
                below = 0;
                for (int c = 0; c < 8; c++) begin
                    x = c[2] ? q.mx : q.px;
                    y = c[1] ? q.my : q.py;
                    z = c[0] ? q.mz : q.pz;
                    if (plane_distance(planes[i], x, y, z) < 0) below++;
                end
                if (below == 8) return 0;
            end
        end
        return 1;
    endfunction

    // Driver: expectation is computed at acceptance, with the planes then in force.
    // The head of the pending queue is the beat on the ports until it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            visible_q = {visible_q, predict_visible(pending_q.pop_front())};
        end
        if (!i_rst_n) begin
            start <= 0;
        end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 0;
        end else if (allow_idle && $urandom_range(0, 9) == 0) begin
            idle_left <= $urandom_range(0, 8);
            start <= 0;
        end else if (pending_q.size() > 0) begin
            t_query q;
            q = pending_q[0];
            start <= 1;
            i_operation <= q.op;
            i_pos_x <= q.px; i_pos_y <= q.py; i_pos_z <= q.pz;
            i_max_x <= q.mx; i_max_y <= q.my; i_max_z <= q.mz;
            i_radius <= q.rad;
        end else begin
            start <= 0;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (visible_q.size() == 0) begin
                report("result beat with no expectation");
            end else begin
                logic exp_vis;
                exp_vis = visible_q.pop_front();
                if (o_visible !== exp_vis)
                    report($sformatf("visible %b expected %b", o_visible, exp_vis));
            end
        end
    end

    task automatic write_plane(input int idx, input t_plane p);
        i_cfg_valid <= 1;
        i_cfg_index <= idx[IDX_WIDTH-1:0];
        i_cfg_data <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx < NUM_REGS) planes[idx] = p;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || start || visible_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] coord(input int mode);
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int m;
        logic signed [15:0] a, b;
        m = $urandom_range(0, 3) == 0 ? 0 : 1;
        q.op = t_op'($urandom_range(0, 3));
        q.px = coord(m); q.py = coord(m); q.pz = coord(m);
        q.mx = coord(m); q.my = coord(m); q.mz = coord(m);
        if (q.op[1] && $urandom_range(0, 4) != 0) begin
            // Mostly well-formed boxes, some left inverted.
            a = q.px; b = q.mx; if (a > b) begin q.px = b; q.mx = a; end
            a = q.py; b = q.my; if (a > b) begin q.py = b; q.my = a; end
            a = q.pz; b = q.mz; if (a > b) begin q.pz = b; q.mz = a; end
        end
        q.rad = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 600));
        return q;
    endfunction

    function automatic t_plane rand_plane(input int mode);
        t_plane p;
        if (mode == 0) begin
            p = t_plane'({$urandom, $urandom});
        end else if (mode == 1) begin
            p.nx = 16'sh7fff; p.ny = 16'sh8000; p.nz = 16'sh7fff; p.off = 16'sh8000;
        end else begin
            p.nx = 16'($urandom_range(0, 32767) - 16384);
            p.ny = 16'($urandom_range(0, 32767) - 16384);
            p.nz = 16'($urandom_range(0, 32767) - 16384);
            p.off = 16'($urandom_range(0, 4000) - 3000);
        end
        return p;
    endfunction

    initial begin
        t_query q;
        t_plane p;
        for (int i = 0; i < NUM_REGS; i++) planes[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: planes at reset, extremes, all operations, inverted box.
        for (int k = 0; k < 4; k++) begin
            q.op = t_op'(k);
            q.px = 16'sh8000; q.py = 16'sh7fff; q.pz = 0;
            q.mx = 16'sh7fff; q.my = 16'sh8000; q.mz = 16'sh8000;
            q.rad = 15'h7fff;
            pending_q = {pending_q, q};
        end
        drain();
        // Index out of range must be ignored.
        write_plane(6, rand_plane(1));
        write_plane(7, rand_plane(0));
        for (int i = 0; i < NUM_REGS; i++) write_plane(i, rand_plane(1));
        for (int k = 0; k < 16; k++) begin
            q = rand_query();
            q.op = t_op'(k % 4);
            q.rad = (k & 4) ? 15'h7fff : 15'h0;
            pending_q = {pending_q, q};
        end
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            for (int i = 0; i < NUM_REGS; i++)
                write_plane(i, rand_plane(phase == 0 ? 0 : (phase == 9 ? 1 : 2)));
            allow_idle = (phase < 8);
            for (int k = 0; k < 193; k++) pending_q = {pending_q, rand_query()};
            drain();
        end

        if (errors == 0) begin
            $display("frustum_cull_test test passed");
        end else begin
            $display("frustum_cull_test test failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("frustum_cull_test test failed");
        $finish;
    end
endmodule
